[design/ptv_pkg.sv]
`default_nettype none
package ptv_pkg;

	localparam int MAX_ENTRIES_DEF = 32;
	localparam int NAME_BYTES_DEF  = 8;

	localparam int ADDR_W     = 32;
	localparam int SECTOR_W   = 21;
	localparam int KIND_W     = 8;
	localparam int NAME_W     = 64;
	localparam int STATUS_W   = 4;
	localparam int INDEX_W    = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [ADDR_W-1:0]   MEM_SIZE_RST    = '0;
	localparam logic [SECTOR_W-1:0] SECTOR_SIZE_RST = 21'd4096;
	localparam logic [KIND_W-1:0]   TYPE_A_RST      = 8'd0;
	localparam logic [KIND_W-1:0]   TYPE_B_RST      = 8'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MEM_SIZE    = 2'd0,
		CFG_SECTOR_SIZE = 2'd1,
		CFG_TYPE_A      = 2'd2,
		CFG_TYPE_B      = 2'd3
	} cfg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 4'd0,
		ST_SIZE_ALIGN  = 4'd1,
		ST_OFF_ALIGN   = 4'd2,
		ST_PAST_END    = 4'd3,
		ST_OVERLAP     = 4'd4,
		ST_BAD_TYPE    = 4'd5,
		ST_BAD_NAME    = 4'd6,
		ST_DUPLICATE   = 4'd7,
		ST_FULL        = 4'd8,
		ST_FAILED      = 4'd9
	} status_t;

endpackage
`default_nettype wire

[design/ptv_if.sv]
`default_nettype none
interface ptv_entry_if;
	logic                         valid;
	logic                         ready;
	logic                         first;
	logic [ptv_pkg::ADDR_W-1:0]   offset;
	logic [ptv_pkg::ADDR_W-1:0]   length;
	logic [ptv_pkg::KIND_W-1:0]   kind;
	logic [ptv_pkg::NAME_W-1:0]   name_bytes;

	modport source (output valid, first, offset, length, kind, name_bytes, input ready);
	modport sink   (input valid, first, offset, length, kind, name_bytes, output ready);
endinterface

interface ptv_result_if;
	logic                          valid;
	logic                          ready;
	logic [ptv_pkg::STATUS_W-1:0]  status;
	logic [ptv_pkg::INDEX_W-1:0]   entry_index;
	logic                          table_ok;

	modport source (output valid, status, entry_index, table_ok, input ready);
	modport sink   (input valid, status, entry_index, table_ok, output ready);
endinterface
`default_nettype wire

[design/ptv_ram.sv]
`default_nettype none
module ptv_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = ptv_pkg::MAX_ENTRIES_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [AW-1:0]        waddr,
	input  wire logic [WIDTH-1:0]     wdata,
	input  wire logic                 re,
	input  wire logic [AW-1:0]        raddr,
	output logic      [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

[design/partition_table_validator_core.sv]
// channel | dir | payload                                   | transaction when
// --------+-----+-------------------------------------------+------------------
// entry   | in  | first, offset, length, kind, name_bytes   | valid & ready
// result  | out | status, entry_index, table_ok             | valid & ready
// cfg     | in  | cfg_we, cfg_index, cfg_data               | cfg_we
//
// One entry passes the pre-check, remainder, range, table walk, decide and finish
// steps; an early reject skips to finish. The remainder unit handles one dividend
// bit per cycle (length, then offset); the walk reads the entry RAM at one
// address per cycle. Reset clears config to defaults, the table and the
// sequencer; no RAM clear. A result waiting at the output stalls only the final step.
`default_nettype none
module partition_table_validator_core #(
	parameter int MAX_ENTRIES = ptv_pkg::MAX_ENTRIES_DEF,
	parameter int NAME_BYTES  = ptv_pkg::NAME_BYTES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ptv_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ptv_pkg::CFG_DATA_W-1:0]    cfg_data,
	ptv_entry_if.sink                              entry,
	ptv_result_if.source                           result
);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int NW = 8 * NAME_BYTES;
	localparam int RW = 2 * ptv_pkg::ADDR_W + NW;
	localparam int XW = ptv_pkg::ADDR_W + 1;
	localparam int SW = ptv_pkg::SECTOR_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_PRE    = 7'b0000010,
		S_REM    = 7'b0000100,
		S_RANGE  = 7'b0001000,
		S_WALK   = 7'b0010000,
		S_DECIDE = 7'b0100000,
		S_FIN    = 7'b1000000
	} state_t;

	function automatic logic is_alnum(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a) ||
		       (b >= 8'h61 && b <= 8'h7a);
	endfunction

	function automatic logic name_valid(input logic [NW-1:0] nm);
		logic       live;
		logic       ok;
		logic [7:0] b;
		live = 1'b1;
		ok   = 1'b1;
		for (int i = 0; i < NAME_BYTES; i++) begin
			b = nm[8*i +: 8];
			if (live) begin
				if (!is_alnum(b)) begin
					live = 1'b0;
					if (b != 8'h00) begin
						ok = 1'b0;
					end
				end
			end
		end
		return ok;
	endfunction

	function automatic logic names_equal(input logic [NW-1:0] a, input logic [NW-1:0] b);
		logic live;
		logic eq;
		live = 1'b1;
		eq   = 1'b1;
		for (int i = 0; i < NAME_BYTES; i++) begin
			if (live) begin
				if (a[8*i +: 8] != b[8*i +: 8]) begin
					eq   = 1'b0;
					live = 1'b0;
				end else if (a[8*i +: 8] == 8'h00) begin
					live = 1'b0;
				end
			end
		end
		return eq;
	endfunction

	state_t state_q;

	logic [ptv_pkg::ADDR_W-1:0]   mem_size_q;
	logic [SW-1:0]                sector_size_q;
	logic [ptv_pkg::KIND_W-1:0]   type_a_q;
	logic [ptv_pkg::KIND_W-1:0]   type_b_q;

	logic [ptv_pkg::ADDR_W-1:0]   off_q;
	logic [ptv_pkg::ADDR_W-1:0]   len_q;
	logic [ptv_pkg::KIND_W-1:0]   kind_q;
	logic [NW-1:0]                name_q;
	logic [XW-1:0]                end_q;

	logic [CW-1:0]                count_q;
	logic                         failed_q;
	ptv_pkg::status_t             status_q;
	logic [ptv_pkg::INDEX_W-1:0]  idx_q;

	logic [SW-1:0]                rem_q;
	logic [ptv_pkg::ADDR_W-1:0]   div_q;
	logic [4:0]                   bit_q;
	logic                         rem_off_q;

	logic [CW-1:0]                walk_q;
	logic                         rd_v_s1;
	logic                         rd_v_s2;
	logic [XW-1:0]                so_s2;
	logic [XW-1:0]                se_s2;
	logic                         neq_s2;
	logic                         ovl_q;
	logic                         dup_q;

	logic                         out_valid_q;
	logic [ptv_pkg::STATUS_W-1:0] out_status_q;
	logic [ptv_pkg::INDEX_W-1:0]  out_idx_q;
	logic                         out_ok_q;

	logic                         accept;
	logic [SW-1:0]                sec_eff;
	logic [SW:0]                  trial;
	logic [SW:0]                  sec_ext;
	logic [SW-1:0]                rem_nx;
	logic [CW+4:0]                cnt_ext;
	logic [XW-1:0]                off_ext;
	logic                         hit;
	logic                         rd_en;
	logic                         wr_en;
	logic [RW-1:0]                rd_data;
	logic [ptv_pkg::ADDR_W-1:0]   rd_off;
	logic [ptv_pkg::ADDR_W-1:0]   rd_len;
	logic [NW-1:0]                rd_name;
	ptv_pkg::status_t             dec_status;

	assign accept  = entry.valid && entry.ready;
	assign sec_eff = (sector_size_q == '0) ? SW'(1) : sector_size_q;
	assign trial   = {rem_q, div_q[ptv_pkg::ADDR_W-1]};
	assign sec_ext = {1'b0, sec_eff};
	assign rem_nx  = (trial >= sec_ext) ? SW'(trial - sec_ext) : trial[SW-1:0];
	assign cnt_ext = {5'd0, count_q};
	assign off_ext = {1'b0, off_q};

	assign rd_off  = rd_data[ptv_pkg::ADDR_W-1:0];
	assign rd_len  = rd_data[2*ptv_pkg::ADDR_W-1:ptv_pkg::ADDR_W];
	assign rd_name = rd_data[RW-1:2*ptv_pkg::ADDR_W];

	assign hit = (off_ext == so_s2) ||
	             (off_ext > so_s2 && off_ext < se_s2) ||
	             (end_q > so_s2 && end_q < se_s2) ||
	             (off_ext <= so_s2 && end_q >= se_s2);

	assign rd_en = (state_q == S_WALK) && (walk_q != count_q);

	always_comb begin
		dec_status = ptv_pkg::ST_OK;
		wr_en      = 1'b0;
		if (ovl_q) begin
			dec_status = ptv_pkg::ST_OVERLAP;
		end else if (kind_q != type_a_q && kind_q != type_b_q) begin
			dec_status = ptv_pkg::ST_BAD_TYPE;
		end else if (!name_valid(name_q)) begin
			dec_status = ptv_pkg::ST_BAD_NAME;
		end else if (dup_q) begin
			dec_status = ptv_pkg::ST_DUPLICATE;
		end else begin
			wr_en = (state_q == S_DECIDE);
		end
	end

	ptv_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[AW-1:0]),
		.wdata ({name_q, len_q, off_q}),
		.re    (rd_en),
		.raddr (walk_q[AW-1:0]),
		.rdata (rd_data)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_size_q    <= ptv_pkg::MEM_SIZE_RST;
			sector_size_q <= ptv_pkg::SECTOR_SIZE_RST;
			type_a_q      <= ptv_pkg::TYPE_A_RST;
			type_b_q      <= ptv_pkg::TYPE_B_RST;
		end else if (cfg_we) begin
			case (ptv_pkg::cfg_idx_t'(cfg_index))
				ptv_pkg::CFG_MEM_SIZE:    mem_size_q    <= cfg_data;
				ptv_pkg::CFG_SECTOR_SIZE: sector_size_q <= cfg_data[SW-1:0];
				ptv_pkg::CFG_TYPE_A:      type_a_q      <= cfg_data[ptv_pkg::KIND_W-1:0];
				ptv_pkg::CFG_TYPE_B:      type_b_q      <= cfg_data[ptv_pkg::KIND_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and table control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			failed_q    <= 1'b0;
			rd_v_s1     <= 1'b0;
			rd_v_s2     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
			rd_v_s2 <= rd_v_s1;
			if (out_valid_q && result.ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (entry.first) begin
							count_q  <= '0;
							failed_q <= 1'b0;
						end
						state_q <= S_PRE;
					end
				end
				S_PRE: begin
					if (failed_q) begin
						state_q <= S_FIN;
					end else if (count_q >= MAX_CNT) begin
						failed_q <= 1'b1;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_REM;
					end
				end
				S_REM: begin
					if (bit_q == 5'd31) begin
						if (rem_nx != '0) begin
							failed_q <= 1'b1;
							state_q  <= S_FIN;
						end else if (rem_off_q) begin
							state_q <= S_RANGE;
						end
					end
				end
				S_RANGE: begin
					if (end_q > {1'b0, mem_size_q}) begin
						failed_q <= 1'b1;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (!rd_en && !rd_v_s1 && !rd_v_s2) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (wr_en) begin
						count_q <= count_q + CW'(1);
					end else begin
						failed_q <= 1'b1;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			off_q  <= entry.offset;
			len_q  <= entry.length;
			kind_q <= entry.kind;
			name_q <= entry.name_bytes[NW-1:0];
		end
		case (state_q)
			S_PRE: begin
				end_q     <= {1'b0, off_q} + {1'b0, len_q};
				idx_q     <= cnt_ext[ptv_pkg::INDEX_W-1:0];
				div_q     <= len_q;
				rem_q     <= '0;
				bit_q     <= '0;
				rem_off_q <= 1'b0;
				walk_q    <= '0;
				ovl_q     <= 1'b0;
				dup_q     <= 1'b0;
				if (failed_q) begin
					status_q <= ptv_pkg::ST_FAILED;
				end else begin
					status_q <= ptv_pkg::ST_FULL;
				end
			end
			S_REM: begin
				bit_q <= bit_q + 5'd1;
				if (bit_q == 5'd31) begin
					status_q <= rem_off_q ? ptv_pkg::ST_OFF_ALIGN : ptv_pkg::ST_SIZE_ALIGN;
				end
				if (bit_q == 5'd31 && !rem_off_q) begin
					div_q     <= off_q;
					rem_q     <= '0;
					rem_off_q <= 1'b1;
				end else begin
					rem_q <= rem_nx;
					div_q <= div_q << 1;
				end
			end
			S_RANGE: begin
				status_q <= ptv_pkg::ST_PAST_END;
			end
			S_WALK: begin
				if (rd_en) begin
					walk_q <= walk_q + CW'(1);
				end
				if (rd_v_s2) begin
					ovl_q <= ovl_q | hit;
					dup_q <= dup_q | neq_s2;
				end
			end
			S_DECIDE: begin
				status_q <= dec_status;
			end
			S_FIN: begin
				if (!out_valid_q || result.ready) begin
					out_status_q <= status_q;
					out_idx_q    <= idx_q;
					out_ok_q     <= !failed_q;
				end
			end
			default: ;
		endcase
		if (rd_v_s1) begin
			so_s2  <= {1'b0, rd_off};
			se_s2  <= {1'b0, rd_off} + {1'b0, rd_len};
			neq_s2 <= names_equal(name_q, rd_name);
		end
	end

	assign entry.ready        = (state_q == S_IDLE);
	assign result.valid       = out_valid_q;
	assign result.status      = out_status_q;
	assign result.entry_index = out_idx_q;
	assign result.table_ok    = out_ok_q;
endmodule
`default_nettype wire

[design/ptv_checker.sv]
`default_nettype none
module ptv_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [ptv_pkg::STATUS_W-1:0]  status,
	input wire logic [ptv_pkg::INDEX_W-1:0]   entry_index,
	input wire logic                          table_ok
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(status) && $stable(entry_index) &&
		$stable(table_ok))
		else $error("result payload changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("entry taken while previous transaction in progress");

	a_ok_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == ptv_pkg::ST_OK) == table_ok))
		else $error("table_ok disagrees with status");
endmodule

bind partition_table_validator_core ptv_checker u_ptv_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (entry.valid),
	.in_ready    (entry.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.status      (result.status),
	.entry_index (result.entry_index),
	.table_ok    (result.table_ok)
);
`default_nettype wire
